[src/rkl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rkl_pkg
// Shared types, register indexes, reset values and defaults of the Lorenz
// RK4 integrator.
// ----------------------------------------------------------------------------
package rkl_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int GAIN_BITS     = 31;
    localparam int STEP_BITS     = 17;
    localparam int INIT_BITS     = 32;
    localparam int OUT_BITS      = 32;

    localparam logic [GAIN_BITS-1:0] SIGMA_RST = 31'd655360;
    localparam logic [GAIN_BITS-1:0] BETA_RST  = 31'd174763;
    localparam logic [GAIN_BITS-1:0] RHO_RST   = 31'd1835008;
    localparam logic [STEP_BITS-1:0] STEP_RST  = 17'd655;
    localparam logic [INIT_BITS-1:0] INIT_RST  = 32'd65536;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_SIGMA  = 3'd0,
        CFG_BETA   = 3'd1,
        CFG_RHO    = 3'd2,
        CFG_STEP   = 3'd3,
        CFG_INIT_X = 3'd4,
        CFG_INIT_Y = 3'd5,
        CFG_INIT_Z = 3'd6
    } cfg_idx_t;

    // micro-op slot within one RK4 stage
    typedef enum logic [2:0] {
        SLOT_DX  = 3'd0,
        SLOT_DY  = 3'd1,
        SLOT_XY  = 3'd2,
        SLOT_DZ  = 3'd3,
        SLOT_ACC = 3'd4,
        SLOT_C0  = 3'd5,
        SLOT_C1  = 3'd6,
        SLOT_C2  = 3'd7
    } slot_t;

    localparam logic [1:0] STAGE_FIRST = 2'd0;
    localparam logic [1:0] STAGE_LAST  = 2'd3;
    localparam logic [4:0] PROG_END    = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } top_state_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_ACC,
        MS_RND,
        MS_CLP,
        MS_OUT
    } mul_phase_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_OUT
    } div_phase_t;

endpackage
`default_nettype wire

[src/rkl_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rkl_mul
// Shared signed multiplier: four half-width partial products accumulated in turn,
// then round to nearest (ties away from zero) and clamp.
// ----------------------------------------------------------------------------
module rkl_mul #(
    parameter int WORD_BITS = rkl_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rkl_pkg::FRAC_BITS_DEF,
    parameter int OP_BITS   = WORD_BITS + 3
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic                       half_shift,
    input  wire logic signed [OP_BITS-1:0]  op_a,
    input  wire logic signed [OP_BITS-1:0]  op_b,
    output logic                            done,
    output logic signed [WORD_BITS+4:0]     res
);

    localparam int RW = WORD_BITS + 5;
    localparam int H  = (OP_BITS + 1) / 2;
    localparam int PW = 4 * H;
    localparam logic [PW-1:0] CAP = PW'({(RW-1){1'b1}});

    rkl_pkg::mul_phase_t phase_reg, phase_next;
    logic [1:0]          cnt_reg;
    logic [2*H-1:0]      ma_reg, mb_reg;
    logic                neg_reg, half_reg;
    logic [PW-1:0]       acc_reg, acc_next;
    logic [PW-1:0]       q_reg, q_next;
    logic signed [RW-1:0] res_reg, res_next;

    logic [OP_BITS-1:0] ma, mb;
    logic [H-1:0]       ah, bh;
    logic [2*H-1:0]     pp;
    logic [PW-1:0]      rnd;
    logic [RW-1:0]      clp;

    assign ma = op_a[OP_BITS-1] ? (~op_a + 1'b1) : op_a;
    assign mb = op_b[OP_BITS-1] ? (~op_b + 1'b1) : op_b;
    assign ah = cnt_reg[1] ? ma_reg[2*H-1:H] : ma_reg[H-1:0];
    assign bh = cnt_reg[0] ? mb_reg[2*H-1:H] : mb_reg[H-1:0];
    assign pp = ah * bh;

    always_comb begin
        case (cnt_reg)
            2'd0:    acc_next = acc_reg + PW'(pp);
            2'd3:    acc_next = acc_reg + (PW'(pp) << (2 * H));
            default: acc_next = acc_reg + (PW'(pp) << H);
        endcase
    end

    always_comb begin
        rnd    = acc_reg + (half_reg ? (PW'(1) << FRAC_BITS) : (PW'(1) << (FRAC_BITS - 1)));
        q_next = half_reg ? (rnd >> (FRAC_BITS + 1)) : (rnd >> FRAC_BITS);
        clp    = (q_reg > CAP) ? CAP[RW-1:0] : q_reg[RW-1:0];
        res_next = neg_reg ? -$signed(clp) : $signed(clp);
    end

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            rkl_pkg::MS_IDLE: if (start) phase_next = rkl_pkg::MS_ACC;
            rkl_pkg::MS_ACC:  if (cnt_reg == 2'd3) phase_next = rkl_pkg::MS_RND;
            rkl_pkg::MS_RND:  phase_next = rkl_pkg::MS_CLP;
            rkl_pkg::MS_CLP:  phase_next = rkl_pkg::MS_OUT;
            rkl_pkg::MS_OUT:  phase_next = rkl_pkg::MS_IDLE;
            default:          phase_next = rkl_pkg::MS_IDLE;
        endcase
    end

    always_comb begin
        done = (phase_reg == rkl_pkg::MS_OUT);
        res  = res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rkl_pkg::MS_IDLE;
            cnt_reg   <= 2'd0;
        end else begin
            phase_reg <= phase_next;
            if (phase_reg == rkl_pkg::MS_ACC) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else begin
                cnt_reg <= 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == rkl_pkg::MS_IDLE && start) begin
            ma_reg   <= (2*H)'(ma);
            mb_reg   <= (2*H)'(mb);
            neg_reg  <= op_a[OP_BITS-1] ^ op_b[OP_BITS-1];
            half_reg <= half_shift;
            acc_reg  <= '0;
        end
        if (phase_reg == rkl_pkg::MS_ACC) begin
            acc_reg <= acc_next;
        end
        if (phase_reg == rkl_pkg::MS_RND) begin
            q_reg <= q_next;
        end
        if (phase_reg == rkl_pkg::MS_CLP) begin
            res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

[src/rkl_div6.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rkl_div6
// Signed divide by six, rounded to nearest with ties away from zero;
// multiply by a constant reciprocal, four partial products accumulated in turn.
// ----------------------------------------------------------------------------
module rkl_div6 #(
    parameter int WORD_BITS = rkl_pkg::WORD_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic signed [WORD_BITS+4:0] dividend,
    output logic                             done,
    output logic signed [WORD_BITS+4:0]      quotient
);

    localparam int RW = WORD_BITS + 5;
    localparam int SH = RW + 3;
    localparam int H  = (RW + 2) / 2;
    localparam int PW = 4 * H;
    localparam logic [63:0]    RECIP   = ((64'd1 << SH) + 64'd5) / 64'd6;
    localparam logic [2*H-1:0] RECIP_W = RECIP[2*H-1:0];

    rkl_pkg::div_phase_t phase_reg, phase_next;
    logic [1:0]     cnt_reg;
    logic [2*H-1:0] n_reg;
    logic [PW-1:0]  acc_reg, acc_next;
    logic           neg_reg;
    logic [RW-1:0]  mag;
    logic [H-1:0]   nh, rh;
    logic [2*H-1:0] pp;
    logic [RW-1:0]  quo;

    assign mag = (dividend[RW-1] ? (~dividend + 1'b1) : dividend) + RW'(3);
    assign nh  = cnt_reg[1] ? n_reg[2*H-1:H] : n_reg[H-1:0];
    assign rh  = cnt_reg[0] ? RECIP_W[2*H-1:H] : RECIP_W[H-1:0];
    assign pp  = nh * rh;
    assign quo = RW'(acc_reg >> SH);

    always_comb begin
        case (cnt_reg)
            2'd0:    acc_next = acc_reg + PW'(pp);
            2'd3:    acc_next = acc_reg + (PW'(pp) << (2 * H));
            default: acc_next = acc_reg + (PW'(pp) << H);
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            rkl_pkg::DV_IDLE: if (start) phase_next = rkl_pkg::DV_RUN;
            rkl_pkg::DV_RUN:  if (cnt_reg == 2'd3) phase_next = rkl_pkg::DV_OUT;
            rkl_pkg::DV_OUT:  phase_next = rkl_pkg::DV_IDLE;
            default:          phase_next = rkl_pkg::DV_IDLE;
        endcase
    end

    always_comb begin
        done     = (phase_reg == rkl_pkg::DV_OUT);
        quotient = neg_reg ? -$signed(quo) : $signed(quo);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rkl_pkg::DV_IDLE;
            cnt_reg   <= 2'd0;
        end else begin
            phase_reg <= phase_next;
            if (phase_reg == rkl_pkg::DV_RUN) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else begin
                cnt_reg <= 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == rkl_pkg::DV_IDLE && start) begin
            n_reg   <= (2*H)'(mag);
            acc_reg <= '0;
            neg_reg <= dividend[RW-1];
        end
        if (phase_reg == rkl_pkg::DV_RUN) begin
            acc_reg <= acc_next;
        end
    end

endmodule
`default_nettype wire

[src/rk4_chaotic_oscillator.sv]
`default_nettype none
// Sequence: a restart beat loads the initial state and goes to the done state, which loads
// the result once the output is free. A step beat makes 28 passes through the shared
// multiplier, 4 accumulate slots and 3 divides by six, then loads the result the same way.
// Flow: one beat at a time; s_tready is high only while the sequencer is idle, so a new
// beat is taken only once the result of the last one has been loaded.
// Reset: aresetn low clears state to the origin, time to zero, registers to defaults.
// ----------------------------------------------------------------------------
// rk4_chaotic_oscillator
// Lorenz system integrated by classical RK4 in saturating fixed point on one
// shared multiplier under a 32-slot micro-sequencer.
// ----------------------------------------------------------------------------
module rk4_chaotic_oscillator #(
    parameter int WORD_BITS = rkl_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rkl_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [0] restart
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [127:0]                           m_tdata,   // time_now, pos_x, pos_y, pos_z
    input  wire logic                              cfg_we,
    input  wire logic [rkl_pkg::CFG_ADDR_BITS-1:0] cfg_index,
    input  wire logic [rkl_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int W   = WORD_BITS;
    localparam int OPW = (W + 3 > 32) ? W + 3 : 32;
    localparam int RW  = W + 5;
    localparam int XW  = (RW > OPW + 1) ? RW : OPW + 1;
    localparam int AW  = W + 3;
    localparam int OW  = (W > 32) ? W : 32;
    localparam logic signed [XW-1:0] WMAX = XW'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [XW-1:0] WMIN = ~WMAX;
    localparam logic signed [OW-1:0] OMAX = OW'(32'sh7fffffff);
    localparam logic signed [OW-1:0] OMIN = OW'($signed(32'h80000000));

    function automatic logic signed [W-1:0] satw(input logic signed [XW-1:0] v);
        logic signed [W-1:0] r;
        if (v > WMAX) begin
            r = WMAX[W-1:0];
        end else if (v < WMIN) begin
            r = WMIN[W-1:0];
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] out32(input logic signed [W-1:0] v);
        logic signed [OW-1:0] e;
        logic [31:0]          r;
        e = OW'(v);
        if (e > OMAX) begin
            r = 32'h7fffffff;
        end else if (e < OMIN) begin
            r = 32'h80000000;
        end else begin
            r = e[31:0];
        end
        return r;
    endfunction

    // configuration
    logic [rkl_pkg::GAIN_BITS-1:0] sigma_reg, beta_reg, rho_reg;
    logic [rkl_pkg::STEP_BITS-1:0] step_reg;
    logic [rkl_pkg::INIT_BITS-1:0] init_x_reg, init_y_reg, init_z_reg;

    // working state
    rkl_pkg::top_state_t  state_reg, state_next;
    logic [4:0]           idx_reg;
    logic signed [W-1:0]  s_reg [3];
    logic signed [W-1:0]  t_reg [3];
    logic signed [W-1:0]  k_reg [3];
    logic signed [AW-1:0] acc_reg [3];
    logic signed [W-1:0]  tmp_reg;
    logic [31:0]          elapsed_reg;
    logic                 m_tvalid_reg;
    logic [127:0]         m_tdata_reg;

    logic [1:0]           stage;
    rkl_pkg::slot_t       slot;
    logic [1:0]           ci;
    logic                 is_final;
    logic signed [W-1:0]  px, py, pz, diff_yx, rho_z, res_w;
    logic signed [OPW-1:0] op_a, op_b;
    logic                 half_shift;
    logic                 mul_start, mul_done, div_start, div_done, out_load;
    logic signed [RW-1:0] mul_res, div_q;
    logic [32:0]          time_sum;

    assign stage    = idx_reg[4:3];
    assign slot     = rkl_pkg::slot_t'(idx_reg[2:0]);
    assign ci       = 2'(idx_reg[2:0] - 3'd5);
    assign is_final = (stage == rkl_pkg::STAGE_LAST) &&
                      (slot == rkl_pkg::SLOT_C0 || slot == rkl_pkg::SLOT_C1 ||
                       slot == rkl_pkg::SLOT_C2);

    // operand select
    always_comb begin
        px = (stage == rkl_pkg::STAGE_FIRST) ? s_reg[0] : t_reg[0];
        py = (stage == rkl_pkg::STAGE_FIRST) ? s_reg[1] : t_reg[1];
        pz = (stage == rkl_pkg::STAGE_FIRST) ? s_reg[2] : t_reg[2];
        diff_yx = satw(XW'(py) - XW'(px));
        rho_z   = satw(XW'($signed({1'b0, rho_reg})) - XW'(pz));
        half_shift = 1'b0;
        case (slot)
            rkl_pkg::SLOT_DX: begin
                op_a = OPW'($signed({1'b0, sigma_reg}));
                op_b = OPW'(diff_yx);
            end
            rkl_pkg::SLOT_DY: begin
                op_a = OPW'(px);
                op_b = OPW'(rho_z);
            end
            rkl_pkg::SLOT_XY: begin
                op_a = OPW'(px);
                op_b = OPW'(py);
            end
            rkl_pkg::SLOT_DZ: begin
                op_a = OPW'($signed({1'b0, beta_reg}));
                op_b = OPW'(pz);
            end
            default: begin
                op_a = OPW'($signed({1'b0, step_reg}));
                op_b = (stage == rkl_pkg::STAGE_LAST) ? OPW'(acc_reg[ci]) : OPW'(k_reg[ci]);
                half_shift = !stage[1];
            end
        endcase
    end

    assign res_w    = satw(XW'(mul_res));
    assign time_sum = {1'b0, elapsed_reg} + 33'(step_reg);

    rkl_mul #(
        .WORD_BITS(WORD_BITS),
        .FRAC_BITS(FRAC_BITS),
        .OP_BITS  (OPW)
    ) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mul_start),
        .half_shift(half_shift),
        .op_a      (op_a),
        .op_b      (op_b),
        .done      (mul_done),
        .res       (mul_res)
    );

    rkl_div6 #(
        .WORD_BITS(WORD_BITS)
    ) u_div6 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(mul_res),
        .done    (div_done),
        .quotient(div_q)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rkl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = s_tdata[0] ? rkl_pkg::ST_DONE : rkl_pkg::ST_ISSUE;
                end
            end
            rkl_pkg::ST_ISSUE: begin
                state_next = (slot == rkl_pkg::SLOT_ACC) ? rkl_pkg::ST_ISSUE : rkl_pkg::ST_MUL;
            end
            rkl_pkg::ST_MUL: begin
                if (mul_done) begin
                    state_next = is_final ? rkl_pkg::ST_DIV : rkl_pkg::ST_ISSUE;
                end
            end
            rkl_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = (idx_reg == rkl_pkg::PROG_END) ? rkl_pkg::ST_DONE
                                                                : rkl_pkg::ST_ISSUE;
                end
            end
            rkl_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) state_next = rkl_pkg::ST_IDLE;
            end
            default: state_next = rkl_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready  = (state_reg == rkl_pkg::ST_IDLE);
        mul_start = (state_reg == rkl_pkg::ST_ISSUE) && (slot != rkl_pkg::SLOT_ACC);
        div_start = (state_reg == rkl_pkg::ST_MUL) && mul_done && is_final;
        out_load  = (state_reg == rkl_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);
        m_tvalid  = m_tvalid_reg;
        m_tdata   = m_tdata_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rkl_pkg::ST_IDLE;
            idx_reg      <= 5'd0;
            m_tvalid_reg <= 1'b0;
            elapsed_reg  <= 32'd0;
            for (int i = 0; i < 3; i++) begin
                s_reg[i] <= '0;
            end
            sigma_reg  <= rkl_pkg::SIGMA_RST;
            beta_reg   <= rkl_pkg::BETA_RST;
            rho_reg    <= rkl_pkg::RHO_RST;
            step_reg   <= rkl_pkg::STEP_RST;
            init_x_reg <= rkl_pkg::INIT_RST;
            init_y_reg <= rkl_pkg::INIT_RST;
            init_z_reg <= rkl_pkg::INIT_RST;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (rkl_pkg::cfg_idx_t'(cfg_index))
                    rkl_pkg::CFG_SIGMA:  sigma_reg  <= cfg_data[rkl_pkg::GAIN_BITS-1:0];
                    rkl_pkg::CFG_BETA:   beta_reg   <= cfg_data[rkl_pkg::GAIN_BITS-1:0];
                    rkl_pkg::CFG_RHO:    rho_reg    <= cfg_data[rkl_pkg::GAIN_BITS-1:0];
                    rkl_pkg::CFG_STEP:   step_reg   <= cfg_data[rkl_pkg::STEP_BITS-1:0];
                    rkl_pkg::CFG_INIT_X: init_x_reg <= cfg_data;
                    rkl_pkg::CFG_INIT_Y: init_y_reg <= cfg_data;
                    rkl_pkg::CFG_INIT_Z: init_z_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                idx_reg <= 5'd0;
                if (s_tdata[0]) begin
                    s_reg[0]    <= satw(XW'($signed(init_x_reg)));
                    s_reg[1]    <= satw(XW'($signed(init_y_reg)));
                    s_reg[2]    <= satw(XW'($signed(init_z_reg)));
                    elapsed_reg <= 32'd0;
                end
            end
            if (state_reg == rkl_pkg::ST_ISSUE && slot == rkl_pkg::SLOT_ACC) begin
                idx_reg <= idx_reg + 5'd1;
            end
            if (state_reg == rkl_pkg::ST_MUL && mul_done && !is_final) begin
                idx_reg <= idx_reg + 5'd1;
            end
            if (state_reg == rkl_pkg::ST_DIV && div_done) begin
                s_reg[ci] <= satw(XW'(s_reg[ci]) + XW'(div_q));
                if (idx_reg == rkl_pkg::PROG_END) begin
                    elapsed_reg <= time_sum[32] ? 32'hffffffff : time_sum[31:0];
                end else begin
                    idx_reg <= idx_reg + 5'd1;
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == rkl_pkg::ST_ISSUE && slot == rkl_pkg::SLOT_ACC) begin
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= ((stage == rkl_pkg::STAGE_FIRST) ? AW'(0) : acc_reg[i]) +
                              ((stage[0] ^ stage[1]) ? (AW'(k_reg[i]) <<< 1) : AW'(k_reg[i]));
            end
        end
        if (state_reg == rkl_pkg::ST_MUL && mul_done) begin
            case (slot)
                rkl_pkg::SLOT_DX: k_reg[0] <= res_w;
                rkl_pkg::SLOT_DY: k_reg[1] <= satw(XW'(res_w) - XW'(py));
                rkl_pkg::SLOT_XY: tmp_reg  <= res_w;
                rkl_pkg::SLOT_DZ: k_reg[2] <= satw(XW'(tmp_reg) - XW'(res_w));
                default: begin
                    if (!is_final) t_reg[ci] <= satw(XW'(s_reg[ci]) + XW'(res_w));
                end
            endcase
        end
        if (out_load) begin
            m_tdata_reg <= {out32(s_reg[2]), out32(s_reg[1]), out32(s_reg[0]), elapsed_reg};
        end
    end

    a_mul_in_mul_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == rkl_pkg::ST_MUL)
        else $error("multiplier finished outside its wait state");

    a_div_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == rkl_pkg::ST_DIV)
        else $error("divider finished outside its wait state");

    a_step_starts_program: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tdata[0]) |=> (state_reg == rkl_pkg::ST_ISSUE &&
                                                  idx_reg == 5'd0))
        else $error("step beat did not start the program at slot zero");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == rkl_pkg::ST_DONE)
        else $error("result raised outside the done state");

endmodule
`default_nettype wire
